// ----- rtl/core/sads_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and codes for the two-stacks-in-one-array unit.
package sads_pkg;

  // Fixed field widths of the request and response beats
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned SLOT_W   = 7;
  localparam int unsigned STATUS_W = 2;

  // Request kinds
  typedef enum logic {
    REQ_PUSH = 1'b0,
    REQ_POP  = 1'b1
  } req_e;

  // Stack selection
  typedef enum logic {
    STACK_LOWER = 1'b0,
    STACK_UPPER = 1'b1
  } stack_e;

  // Response status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  // Controller states
  typedef enum logic {
    CS_IDLE = 1'b0,
    CS_READ = 1'b1
  } ctrl_state_e;

  // Controller to datapath commands
  typedef struct packed {
    logic    push_we;     // write the store, bump the selected pointer
    logic    pop_rd;      // read the store, drop the selected pointer
    logic    upper;       // selected stack is the upper one
    logic    load_imm;    // load the output register with an immediate result
    logic    load_pop;    // load the output register with the read data
    status_e imm_status;  // status for an immediate result
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic full;         // both stacks together fill the store
    logic lower_empty;
    logic upper_empty;
    logic out_free;     // output register can take a result this cycle
  } dp_sts_t;

endpackage

// ----- rtl/core/sads_if.sv -----
`timescale 1ns / 1ps
// Request and response channel interfaces.
interface sads_req_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 req_type;
  logic                                 stack_sel;
  logic signed [sads_pkg::VALUE_W-1:0]  push_value;

  modport source (output valid, output req_type, output stack_sel, output push_value,
                  input ready);
  modport sink   (input valid, input req_type, input stack_sel, input push_value,
                  output ready);
endinterface

interface sads_rsp_if;
  logic                                 valid;
  logic                                 ready;
  logic [sads_pkg::STATUS_W-1:0]        status;
  logic signed [sads_pkg::VALUE_W-1:0]  pop_value;
  logic [sads_pkg::SLOT_W-1:0]          slot_index;

  modport source (output valid, output status, output pop_value, output slot_index,
                  input ready);
  modport sink   (input valid, input status, input pop_value, input slot_index,
                  output ready);
endinterface

// ----- rtl/core/sads_ctrl.sv -----
`timescale 1ns / 1ps
// Request sequencer: accepts beats and issues store and output commands.
module sads_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_req_type_i,
  input  logic              in_stack_sel_i,
  output logic              in_ready_o,
  input  sads_pkg::dp_sts_t sts_i,
  output sads_pkg::cmd_t    cmd_o
);
  import sads_pkg::*;

  ctrl_state_e state_q, state_d;
  logic        accept;
  logic        is_pop;
  logic        upper;
  logic        sel_empty;

  assign is_pop    = (in_req_type_i == REQ_POP);
  assign upper     = (in_stack_sel_i == STACK_UPPER);
  assign sel_empty = upper ? sts_i.upper_empty : sts_i.lower_empty;
  assign accept    = in_valid_i && in_ready_o;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CS_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state: a good pop goes to CS_READ for the store read, then back to idle
  always_comb begin
    state_d = state_q;
    case (state_q)
      CS_IDLE: begin
        if (accept && is_pop && !sel_empty) state_d = CS_READ;
      end
      CS_READ: begin
        state_d = CS_IDLE;
      end
      default: begin
        state_d = CS_IDLE;
      end
    endcase
  end

  // Outputs
  always_comb begin
    in_ready_o       = 1'b0;
    cmd_o            = '0;
    cmd_o.upper      = upper;
    cmd_o.imm_status = ST_OK;
    case (state_q)
      CS_IDLE: begin
        in_ready_o = sts_i.out_free;
        if (in_valid_i && sts_i.out_free) begin
          if (!is_pop) begin
            cmd_o.load_imm = 1'b1;
            if (sts_i.full) begin
              cmd_o.imm_status = ST_FULL;
            end else begin
              cmd_o.push_we = 1'b1;
            end
          end else if (sel_empty) begin
            cmd_o.load_imm   = 1'b1;
            cmd_o.imm_status = ST_EMPTY;
          end else begin
            cmd_o.pop_rd = 1'b1;
          end
        end
      end
      CS_READ: begin
        cmd_o.load_pop = 1'b1;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

endmodule

// ----- rtl/core/sads_datapath.sv -----
`timescale 1ns / 1ps
// Shared element store, the two stack pointers and the output register.
module sads_datapath #(
  parameter int unsigned DEPTH      = 128,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic [sads_pkg::VALUE_W-1:0]        push_value_i,
  input  sads_pkg::cmd_t                      cmd_i,
  output sads_pkg::dp_sts_t                   sts_o,
  input  logic                                out_ready_i,
  output logic                                out_valid_o,
  output logic [sads_pkg::STATUS_W-1:0]       out_status_o,
  output logic [sads_pkg::VALUE_W-1:0]        out_pop_value_o,
  output logic [sads_pkg::SLOT_W-1:0]         out_slot_index_o
);
  import sads_pkg::*;

  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned AW = $clog2(DEPTH);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
  localparam logic [CW-1:0] TOP_C   = CW'(DEPTH - 1);
  localparam logic [CW:0]   FULL_C  = (CW + 1)'(DEPTH);

  logic [DATA_WIDTH-1:0] store_mem [DEPTH];
  logic [DATA_WIDTH-1:0] rd_data_q;
  logic [CW-1:0]         lower_cnt_q, lower_cnt_d;
  logic [CW-1:0]         upper_cnt_q, upper_cnt_d;
  logic [CW:0]           used_sum;
  logic [CW-1:0]         push_slot_c;
  logic [CW-1:0]         pop_slot_c;
  logic [AW-1:0]         push_slot;
  logic [AW-1:0]         pop_slot;
  logic [AW+SLOT_W-1:0]  slot_ext;
  logic [DATA_WIDTH+VALUE_W-1:0] wr_ext;
  logic [DATA_WIDTH+VALUE_W-1:0] rd_ext;
  logic [DATA_WIDTH-1:0] wr_data;

  logic                  out_valid_q, out_valid_d;
  logic [STATUS_W-1:0]   out_status_q;
  logic [VALUE_W-1:0]    out_pop_q;
  logic [SLOT_W-1:0]     out_slot_q;

  // Occupancy and status to the controller
  assign used_sum          = {1'b0, lower_cnt_q} + {1'b0, upper_cnt_q};
  assign sts_o.full        = (used_sum >= FULL_C);
  assign sts_o.lower_empty = (lower_cnt_q == '0);
  assign sts_o.upper_empty = (upper_cnt_q == '0);
  assign sts_o.out_free    = !out_valid_q || out_ready_i;

  // Slot addresses: the upper stack counts down from the top slot
  assign push_slot_c = cmd_i.upper ? (TOP_C - upper_cnt_q) : lower_cnt_q;
  assign pop_slot_c  = cmd_i.upper ? (DEPTH_C - upper_cnt_q) : (lower_cnt_q - 1'b1);
  assign push_slot   = push_slot_c[AW-1:0];
  assign pop_slot    = pop_slot_c[AW-1:0];
  assign slot_ext    = {{SLOT_W{1'b0}}, push_slot};

  // Width adaptation of stored values, sign kept both ways
  assign wr_ext  = {{DATA_WIDTH{push_value_i[VALUE_W-1]}}, push_value_i};
  assign wr_data = wr_ext[DATA_WIDTH-1:0];
  assign rd_ext  = {{VALUE_W{rd_data_q[DATA_WIDTH-1]}}, rd_data_q};

  // Element store, one write or one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (cmd_i.push_we) begin
      store_mem[push_slot] <= wr_data;
    end
    if (cmd_i.pop_rd) begin
      rd_data_q <= store_mem[pop_slot];
    end
  end

  // Stack pointers
  always_comb begin
    lower_cnt_d = lower_cnt_q;
    upper_cnt_d = upper_cnt_q;
    if (cmd_i.push_we) begin
      if (cmd_i.upper) upper_cnt_d = upper_cnt_q + 1'b1;
      else             lower_cnt_d = lower_cnt_q + 1'b1;
    end else if (cmd_i.pop_rd) begin
      if (cmd_i.upper) upper_cnt_d = upper_cnt_q - 1'b1;
      else             lower_cnt_d = lower_cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lower_cnt_q <= '0;
      upper_cnt_q <= '0;
    end else begin
      lower_cnt_q <= lower_cnt_d;
      upper_cnt_q <= upper_cnt_d;
    end
  end

  // Output register valid
  always_comb begin
    out_valid_d = out_valid_q && !out_ready_i;
    if (cmd_i.load_imm || cmd_i.load_pop) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // Output register payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_imm) begin
      out_status_q <= cmd_i.imm_status;
      out_pop_q    <= '0;
      out_slot_q   <= cmd_i.push_we ? slot_ext[SLOT_W-1:0] : '0;
    end else if (cmd_i.load_pop) begin
      out_status_q <= ST_OK;
      out_pop_q    <= rd_ext[VALUE_W-1:0];
      out_slot_q   <= '0;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign out_status_o     = out_status_q;
  assign out_pop_value_o  = out_pop_q;
  assign out_slot_index_o = out_slot_q;

endmodule

// ----- rtl/core/shared_array_dual_stack_unit.sv -----
`timescale 1ns / 1ps
// Two LIFO stacks sharing one element store: a lower stack growing up from slot 0
// and an upper stack growing down from slot DEPTH-1. Every request beat gives one
// response beat. A push, or any failed request (full on push, empty on pop), has
// its response in the output register in the cycle after acceptance; a successful
// pop goes through the registered store read port first. A new request is taken
// while the output register is empty or being drained in that cycle and no pop
// read is pending, so pushes and failed requests run at one per cycle unless the
// output stalls; a successful pop holds off the next request until it is loaded.
// Pointers come up empty at reset; the store is not cleared and needs no init pass.
module shared_array_dual_stack_unit #(
  parameter int unsigned DEPTH      = 128,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  sads_req_if.sink   req_i,
  sads_rsp_if.source rsp_o
);
  import sads_pkg::*;

  cmd_t    cmd;
  dp_sts_t sts;
  logic    in_ready;

  assign req_i.ready = in_ready;

  // Sequencer
  sads_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (req_i.valid),
    .in_req_type_i  (req_i.req_type),
    .in_stack_sel_i (req_i.stack_sel),
    .in_ready_o     (in_ready),
    .sts_i          (sts),
    .cmd_o          (cmd)
  );

  // Store, pointers and output register
  sads_datapath #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .push_value_i     (req_i.push_value),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .out_ready_i      (rsp_o.ready),
    .out_valid_o      (rsp_o.valid),
    .out_status_o     (rsp_o.status),
    .out_pop_value_o  (rsp_o.pop_value),
    .out_slot_index_o (rsp_o.slot_index)
  );

endmodule

// ----- rtl/core/sads_checker.sv -----
`timescale 1ns / 1ps
// Port-level checks for the dual stack unit, bound to the top level.
module sads_port_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          req_valid,
  input logic                          req_ready,
  input logic                          req_type,
  input logic                          rsp_valid,
  input logic                          rsp_ready,
  input logic [sads_pkg::STATUS_W-1:0] rsp_status,
  input logic [sads_pkg::VALUE_W-1:0]  rsp_pop_value,
  input logic [sads_pkg::SLOT_W-1:0]   rsp_slot_index
);
  import sads_pkg::*;

  // A pending response beat holds until taken
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
      && $stable(rsp_pop_value) && $stable(rsp_slot_index))
    else $error("response beat changed while stalled");

  // Only defined status codes leave the block
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid |-> rsp_status == ST_OK || rsp_status == ST_FULL
      || rsp_status == ST_EMPTY)
    else $error("undefined status code");

  // Failed requests report zero payload
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid && rsp_status != ST_OK |-> rsp_pop_value == '0 && rsp_slot_index == '0)
    else $error("failed request carries payload");

  // A push is answered in the next cycle
  a_push_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid && req_ready && req_type == REQ_PUSH |=> rsp_valid)
    else $error("push response not ready one cycle after acceptance");

  // No request is taken while a stalled response still occupies the output
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid && !rsp_ready |-> !req_ready)
    else $error("request taken while output register is blocked");

endmodule

bind shared_array_dual_stack_unit sads_port_checker u_sads_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .req_valid      (req_i.valid),
  .req_ready      (req_i.ready),
  .req_type       (req_i.req_type),
  .rsp_valid      (rsp_o.valid),
  .rsp_ready      (rsp_o.ready),
  .rsp_status     (rsp_o.status),
  .rsp_pop_value  (rsp_o.pop_value),
  .rsp_slot_index (rsp_o.slot_index)
);
